// ===== rtl/gcd_lcm_unit_macros.svh =====
// assertion macros for the gcd and lcm unit checker
`ifndef GCD_LCM_UNIT_MACROS_SVH
`define GCD_LCM_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define GCLU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define GCLU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gclu_pkg.sv =====
// package with word types, states and defaults for the gcd and lcm unit
`timescale 1ns / 1ps

package gclu_pkg;

  localparam int GCLU_WIDTH = 32;

  typedef struct packed {
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic [31:0] divisor;
    logic [63:0] multiple;
  } out_word_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EUCLID = 6'b000010,
    S_GDIV   = 6'b000100,
    S_LDIV   = 6'b001000,
    S_MUL    = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

endpackage

// ===== rtl/gclu_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module gclu_div import gclu_pkg::*; #(
  parameter int WIDTH = GCLU_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;
  logic             ge;

  assign rem_sh = {rem, quo[WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = ~diff[WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(WIDTH);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy && cnt != '0) begin
      rem <= ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      quo <= {quo[WIDTH-2:0], ge};
    end
  end

  assign done      = busy && (cnt == '0);
  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== rtl/gclu_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module gclu_mul import gclu_pkg::*; #(
  parameter int WIDTH = GCLU_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WIDTH-1:0]   mcand_in,
  input  logic [WIDTH-1:0]   mplier_in,
  output logic               done,
  output logic [2*WIDTH-1:0] product
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [2*WIDTH-1:0] acc;
  logic [2*WIDTH-1:0] mcand;
  logic [WIDTH-1:0]   mplier;
  logic [CW-1:0]      cnt;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(WIDTH);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= {{WIDTH{1'b0}}, mcand_in};
      mplier <= mplier_in;
    end else if (busy && cnt != '0) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[2*WIDTH-2:0], 1'b0};
      mplier <= {1'b0, mplier[WIDTH-1:1]};
    end
  end

  assign done    = busy && (cnt == '0);
  assign product = acc;

endmodule

// ===== rtl/gcd_lcm_unit.sv =====
// gcd and lcm unit: euclid on a shared divider, lcm by divide and shift-add multiply
//
// input channel in_valid / in_stall / in_data carries two unsigned operands;
// bits at or above WIDTH are ignored. output channel out_valid / out_stall /
// out_data carries one word per input word: the gcd and the double-width lcm.
// a zero operand gives the other operand as gcd and a zero lcm.
// one word is worked on at a time; in_stall is high from acceptance until the
// result has moved into the output register.
// a word takes k euclid remainder steps (at most about 46 at 32 bits), each
// occupying the divider, then for the lcm one more divide and a multiply,
// plus sequencing; the shared restoring divider, one quotient bit per cycle,
// dominates the time a word takes.
// the output register holds a finished word while out_stall is high; the next
// input word is accepted then, and its result waits until the register frees.
// reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
`timescale 1ns / 1ps

module gcd_lcm_unit import gclu_pkg::*; #(
  parameter int WIDTH = GCLU_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  state_t state;
  state_t state_next;

  logic [WIDTH-1:0]   x;
  logic [WIDTH-1:0]   y;
  logic [WIDTH-1:0]   a_op;
  logic [WIDTH-1:0]   b_op;
  logic [2*WIDTH-1:0] prod;

  logic               div_start;
  logic [WIDTH-1:0]   div_n;
  logic [WIDTH-1:0]   div_d;
  logic               div_done;
  logic [WIDTH-1:0]   div_quo;
  logic [WIDTH-1:0]   div_rem;
  logic               mul_start;
  logic               mul_done;
  logic [2*WIDTH-1:0] mul_prod;
  logic               out_free;
  logic               ops_zero;

  assign out_free = ~out_valid | ~out_stall;
  assign ops_zero = (a_op == '0) || (b_op == '0);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_n      = a_op;
    div_d      = x;
    mul_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EUCLID;
      end
      S_EUCLID: begin
        if (y != '0) begin
          div_start  = 1'b1;
          div_n      = x;
          div_d      = y;
          state_next = S_GDIV;
        end else if (ops_zero) begin
          state_next = S_FIN;
        end else begin
          div_start  = 1'b1;
          state_next = S_LDIV;
        end
      end
      S_GDIV: begin
        if (div_done) state_next = S_EUCLID;
      end
      S_LDIV: begin
        if (div_done) begin
          mul_start  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        a_op <= in_data.operand_a[WIDTH-1:0];
        b_op <= in_data.operand_b[WIDTH-1:0];
        x    <= in_data.operand_a[WIDTH-1:0];
        y    <= in_data.operand_b[WIDTH-1:0];
        prod <= '0;
      end
      S_GDIV: begin
        if (div_done) begin
          x <= y;
          y <= div_rem;
        end
      end
      S_MUL: begin
        if (mul_done) prod <= mul_prod;
      end
      S_FIN: begin
        if (out_free) begin
          out_data.divisor  <= 32'(x);
          out_data.multiple <= 64'(prod);
        end
      end
      default: begin
      end
    endcase
  end

  gclu_div #(.WIDTH(WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  gclu_mul #(.WIDTH(WIDTH)) u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .mcand_in  (div_quo),
    .mplier_in (b_op),
    .done      (mul_done),
    .product   (mul_prod)
  );

endmodule

// ===== rtl/gclu_checker.sv =====
// port-level checker for the gcd and lcm unit, bound to the top level
`timescale 1ns / 1ps
`include "gcd_lcm_unit_macros.svh"

module gclu_checker import gclu_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  `GCLU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "stalled word dropped")
  `GCLU_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_data), "stalled word changed")
  `GCLU_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "second word taken while busy")
  `GCLU_ASSERT_NOW(a_zero_gcd, clk, rst, out_valid && out_data.divisor == '0, out_data.multiple == '0, "zero gcd with nonzero lcm")

endmodule

bind gcd_lcm_unit gclu_checker u_gclu_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench for the gcd and lcm unit: directed and random operand words
`timescale 1ns / 1ps

module testbench;
  import gclu_pkg::*;

  localparam int OPERAND_BITS = GCLU_WIDTH;
  localparam int STALL_PCT = 13;
  localparam int RANDOM_WORDS = 800;
  localparam int DRAIN_CYCLES = 2000;
  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  out_word_t pending_results[$];
  int        error_count = 0;
  int        words_sent = 0;
  int        words_checked = 0;
  int        quiet_cycles = 0;
  bit        gaps_on = 1'b1;

  gcd_lcm_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic out_word_t gcd_lcm_of(in_word_t w);
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] b;
    out_word_t   res;
    mask = (64'd1 << OPERAND_BITS) - 64'd1;
    a = {32'd0, w.operand_a} & mask;
    b = {32'd0, w.operand_b} & mask;
    x = a;
    y = b;
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    res.divisor = x[31:0];
    res.multiple = (a != 64'd0 && b != 64'd0) ? (a / x) * b : 64'd0;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // one word per call, entered and left at a falling edge
  task automatic send_word(input logic [31:0] a, input logic [31:0] b);
    in_word_t w;
    w.operand_a = a;
    w.operand_b = b;
    if (gaps_on) begin
      while ($urandom_range(99) < STALL_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(gcd_lcm_of(w));
    words_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < STALL_PCT);
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word div=%0d mul=%0d",
                                  out_data.divisor, out_data.multiple));
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (out_data.divisor !== want.divisor)
          report_mismatch($sformatf("divisor got %0d expected %0d",
                                    out_data.divisor, want.divisor));
        if (out_data.multiple !== want.multiple)
          report_mismatch($sformatf("multiple got %0d expected %0d",
                                    out_data.multiple, want.multiple));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                 quiet_cycles, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic test_zero_operands();
    send_word(32'd0, 32'd0);
    send_word(32'd0, 32'd12345);
    send_word(32'd987654, 32'd0);
    send_word(32'd0, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'd0);
  endtask

  task automatic test_extremes();
    send_word(32'd1, 32'd1);
    send_word(32'd1, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_word(32'hFFFF_FFFB, 32'hFFFF_FFFF);
    send_word(32'h5555_5555, 32'hAAAA_AAAA);
    send_word(32'h8000_0000, 32'h4000_0000);
  endtask

  // consecutive fibonacci numbers force long remainder chains
  task automatic test_worst_case_euclid();
    send_word(32'd2971215073, 32'd1836311903);
    send_word(32'd1836311903, 32'd2971215073);
    send_word(32'd1134903170, 32'd701408733);
  endtask

  task automatic test_common_factors();
    send_word(32'd12, 32'd18);
    send_word(32'd65536, 32'd65536);
    send_word(32'd7 * 32'd65521, 32'd7 * 32'd65519);
    send_word(32'd1000000, 32'd999);
    send_word(32'd36, 32'd144);
  endtask

  task automatic test_random_mix();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] g;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      gaps_on = !(i >= 300 && i < 450);
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          a = $urandom;
          b = $urandom;
        end
        4: begin
          a = $urandom_range(1000);
          b = $urandom_range(1000);
        end
        5, 6: begin
          g = $urandom_range(65535, 1);
          a = g * $urandom_range(65535, 1);
          b = g * $urandom_range(65535, 1);
        end
        7: begin
          a = $urandom_range(1) ? 32'd0 : $urandom;
          b = $urandom_range(1) ? 32'd0 : $urandom;
        end
        8: begin
          a = $urandom >> $urandom_range(31);
          b = $urandom >> $urandom_range(31);
        end
        default: begin
          b = $urandom_range(65535, 1);
          a = b * $urandom_range(65535, 1);
          if ($urandom_range(1)) begin
            g = a;
            a = b;
            b = g;
          end
        end
      endcase
      send_word(a, b);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_zero_operands();
    test_extremes();
    test_worst_case_euclid();
    test_common_factors();
    test_random_mix();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d operand words, checked %0d gcd/lcm results", words_sent,
             words_checked);
    $display("covered zero operands, extreme values, long remainder chains, shared factors");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== gcd_lcm_unit.f =====
+incdir+rtl
rtl/gclu_pkg.sv
rtl/gclu_div.sv
rtl/gclu_mul.sv
rtl/gcd_lcm_unit.sv
rtl/gclu_checker.sv
tb/testbench.sv
